### rtl/core/cdt_pkg.sv
// shared constants and codes for the cell dirty tracker
package cdt_pkg;

   localparam int MAX_COLS_DEF  = 128;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int CELL_BITS_DEF = 64;

   localparam logic [2:0] OP_WRITE_CELL = 3'd0;
   localparam logic [2:0] OP_WRITE_FG   = 3'd1;
   localparam logic [2:0] OP_ERASE_SPAN = 3'd2;
   localparam logic [2:0] OP_ERASE_ALL  = 3'd3;
   localparam logic [2:0] OP_FLUSH_ROW  = 3'd4;
   localparam logic [2:0] OP_BOUNDS     = 3'd5;

   localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CFG_BLANK_CELL    = 2'd2;

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [6:0] HEIGHT_RESET = 7'd24;

   typedef logic [63:0] csr_data_type;

endpackage

### rtl/core/cdt_if.sv
// request and response channel interfaces
interface cdt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [6:0]  col;
   logic [5:0]  row;
   logic [7:0]  span_length;
   logic [63:0] cell_value;
   logic [31:0] fg_value;
   modport source (output valid, operation, col, row, span_length, cell_value, fg_value,
                   input ready);
   modport sink (input valid, operation, col, row, span_length, cell_value, fg_value,
                 output ready);
endinterface

interface cdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_col;
   logic [5:0] out_row;
   logic [7:0] out_length;
   logic [6:0] frame_top;
   logic [5:0] frame_bottom;
   logic       last;
   modport source (output valid, out_col, out_row, out_length, frame_top, frame_bottom, last,
                   input ready);
   modport sink (input valid, out_col, out_row, out_length, frame_top, frame_bottom, last,
                 output ready);
endinterface

### rtl/core/cdt_ram.sv
// single port write, single port read synchronous ram
module cdt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/cdt_ctrl.sv
// sequencer: read-modify-write of cells and row bounds, flush walk, clear sweep
module cdt_ctrl #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_ROWS  = 64,
   parameter int CELL_BITS = 64,
   parameter int ADDR_W    = 13,
   parameter int ROW_AW    = 6,
   parameter int COL_W     = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   cdt_req_if.sink                req,
   cdt_rsp_if.source              rsp,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  cdt_pkg::csr_data_type  csr_write_data,
   output logic                   cell_we,
   output logic [ADDR_W-1:0]      cell_waddr,
   output logic [CELL_BITS:0]     cell_wdata,
   output logic [ADDR_W-1:0]      cell_raddr,
   input  logic [CELL_BITS:0]     cell_rdata,
   output logic                   bnd_we,
   output logic [ROW_AW-1:0]      bnd_addr,
   output logic [2*COL_W:0]       bnd_wdata,
   input  logic [2*COL_W:0]       bnd_rdata
);
   import cdt_pkg::*;

   localparam int DEPTH   = MAX_COLS * MAX_ROWS;
   localparam int FG_BITS = CELL_BITS / 2;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_BRD  = 4'd2;
   localparam logic [3:0] S_BLD  = 4'd3;
   localparam logic [3:0] S_CRD  = 4'd4;
   localparam logic [3:0] S_CWR  = 4'd5;
   localparam logic [3:0] S_BWR  = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;
   localparam logic [3:0] S_QRY  = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic [CELL_BITS-1:0] sweep_val_ff, sweep_val_in;
   logic [2:0]           op_ff, op_in;
   logic [5:0]           row_ff, row_in;
   logic [7:0]           end_ff, end_in;
   logic [CELL_BITS-1:0] cval_ff, cval_in;
   logic [FG_BITS-1:0]   fg_ff, fg_in;
   logic                 inside_ff, inside_in;
   logic [COL_W-1:0]     x_ff, x_in;
   logic                 ne_ff, ne_in;
   logic [COL_W-1:0]     left_ff, left_in;
   logic [COL_W-1:0]     right_ff, right_in;
   logic [6:0]           top_ff, top_in;
   logic [5:0]           bot_ff, bot_in;
   logic                 erased_ff, erased_in;
   logic [7:0]           run_len_ff, run_len_in;
   logic [COL_W-1:0]     run_col_ff, run_col_in;
   logic                 cr_valid_ff, cr_valid_in;
   logic [COL_W-1:0]     cr_col_ff, cr_col_in;
   logic [7:0]           cr_len_ff, cr_len_in;
   logic [7:0]           width_ff, width_in;
   logic [6:0]           height_ff, height_in;
   logic [63:0]          blank_ff, blank_in;
   logic                 rv_ff, rv_in;
   logic [6:0]           ocol_ff, ocol_in;
   logic [5:0]           orow_ff, orow_in;
   logic [7:0]           olen_ff, olen_in;
   logic [6:0]           otop_ff, otop_in;
   logic [5:0]           obot_ff, obot_in;
   logic                 olast_ff, olast_in;

   logic [7:0]           ew;
   logic [6:0]           eh;
   logic                 out_free;
   logic [8:0]           span_sum;
   logic [CELL_BITS-1:0] q;
   logic                 d;
   logic [CELL_BITS-1:0] newv;
   logic                 chg;
   logic                 complete;
   logic [COL_W-1:0]     comp_col;
   logic [7:0]           comp_len;
   logic                 row_ok;

   assign ew = (int'(width_ff) > MAX_COLS) ? 8'(MAX_COLS) : width_ff;
   assign eh = (int'(height_ff) > MAX_ROWS) ? 7'(MAX_ROWS) : height_ff;
   assign out_free = !rv_ff || rsp.ready;
   assign q = cell_rdata[CELL_BITS-1:0];
   assign d = cell_rdata[CELL_BITS];
   assign req.ready = (state_ff == S_IDLE);
   assign cell_raddr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(x_ff));
   assign bnd_addr = (state_ff == S_CLR) ? ROW_AW'(sweep_ff) : ROW_AW'(row_ff);

   assign rsp.valid        = rv_ff;
   assign rsp.out_col      = ocol_ff;
   assign rsp.out_row      = orow_ff;
   assign rsp.out_length   = olen_ff;
   assign rsp.frame_top    = otop_ff;
   assign rsp.frame_bottom = obot_ff;
   assign rsp.last         = olast_ff;

   always_comb begin
      state_in = state_ff;   sweep_in = sweep_ff;     sweep_val_in = sweep_val_ff;
      op_in = op_ff;         row_in = row_ff;         end_in = end_ff;
      cval_in = cval_ff;     fg_in = fg_ff;           inside_in = inside_ff;
      x_in = x_ff;           ne_in = ne_ff;           left_in = left_ff;
      right_in = right_ff;   top_in = top_ff;         bot_in = bot_ff;
      erased_in = erased_ff; run_len_in = run_len_ff; run_col_in = run_col_ff;
      cr_valid_in = cr_valid_ff; cr_col_in = cr_col_ff; cr_len_in = cr_len_ff;
      width_in = width_ff;   height_in = height_ff;   blank_in = blank_ff;
      rv_in = rv_ff && !rsp.ready;
      ocol_in = ocol_ff;     orow_in = orow_ff;       olen_in = olen_ff;
      otop_in = otop_ff;     obot_in = obot_ff;       olast_in = olast_ff;
      cell_we = 1'b0;
      cell_waddr = cell_raddr;
      cell_wdata = {1'b0, q};
      bnd_we = 1'b0;
      bnd_wdata = {ne_ff, left_ff, right_ff};
      span_sum = {1'b0, req.col} + {1'b0, req.span_length};
      row_ok = ({1'b0, req.row} < eh);
      newv = cval_ff;
      chg = 1'b0;
      complete = 1'b0;
      comp_col = run_col_ff;
      comp_len = run_len_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CFG_SCREEN_WIDTH:  width_in = csr_write_data[7:0];
            CFG_SCREEN_HEIGHT: height_in = csr_write_data[6:0];
            CFG_BLANK_CELL:    blank_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLR: begin
            cell_we = 1'b1;
            cell_waddr = sweep_ff;
            cell_wdata = {1'b0, sweep_val_ff};
            if (int'(sweep_ff) < MAX_ROWS) begin
               bnd_we = 1'b1;
               bnd_wdata = '0;
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               op_in = req.operation;
               row_in = req.row;
               x_in = COL_W'(req.col);
               cval_in = CELL_BITS'(req.cell_value);
               fg_in = FG_BITS'(req.fg_value);
               end_in = (req.span_length == 8'd0 || span_sum > {1'b0, ew}) ?
                        ew : span_sum[7:0];
               inside_in = row_ok && ({1'b0, req.col} < ew);
               case (req.operation)
                  OP_WRITE_CELL, OP_WRITE_FG, OP_ERASE_SPAN: begin
                     if (row_ok && ({1'b0, req.col} < ew)) begin
                        state_in = S_BRD;
                     end
                  end
                  OP_ERASE_ALL: begin
                     if (!erased_ff) begin
                        sweep_in = '0;
                        sweep_val_in = blank_ff[CELL_BITS-1:0];
                        top_in = eh;
                        bot_in = '0;
                        erased_in = 1'b1;
                        state_in = S_CLR;
                     end
                  end
                  OP_FLUSH_ROW: begin
                     inside_in = row_ok;
                     cr_valid_in = 1'b0;
                     run_len_in = '0;
                     state_in = row_ok ? S_BRD : S_FIN;
                  end
                  OP_BOUNDS: state_in = S_QRY;
                  default: ;
               endcase
            end
         end
         S_BRD: state_in = S_BLD;
         S_BLD: begin
            ne_in = bnd_rdata[2*COL_W];
            left_in = bnd_rdata[2*COL_W-1:COL_W];
            right_in = bnd_rdata[COL_W-1:0];
            state_in = S_CRD;
            if (op_ff == OP_FLUSH_ROW) begin
               x_in = bnd_rdata[2*COL_W-1:COL_W];
               if (!bnd_rdata[2*COL_W]) begin
                  state_in = S_FIN;
               end
            end
         end
         S_CRD: state_in = S_CWR;
         S_CWR: begin
            if (op_ff == OP_FLUSH_ROW) begin
               if (d) begin
                  comp_len = run_len_ff + 8'd1;
                  if (run_len_ff == 8'd0) begin
                     comp_col = x_ff;
                  end
                  complete = (x_ff == right_ff);
               end else begin
                  complete = (run_len_ff != 8'd0);
               end
               // a finished run parks until the one before it has left
               if (!(complete && cr_valid_ff && !out_free)) begin
                  if (d) begin
                     cell_we = 1'b1;
                     cell_wdata = {1'b0, q};
                  end
                  run_len_in = d ? comp_len : 8'd0;
                  run_col_in = comp_col;
                  if (complete) begin
                     if (cr_valid_ff) begin
                        rv_in = 1'b1;
                        ocol_in = 7'(cr_col_ff);
                        orow_in = row_ff;
                        olen_in = cr_len_ff;
                        otop_in = '0;
                        obot_in = '0;
                        olast_in = 1'b0;
                     end
                     cr_valid_in = 1'b1;
                     cr_col_in = comp_col;
                     cr_len_in = comp_len;
                  end
                  if (x_ff == right_ff) begin
                     state_in = S_FIN;
                  end else begin
                     x_in = x_ff + 1'b1;
                     state_in = S_CRD;
                  end
               end
            end else begin
               if (op_ff == OP_WRITE_FG) begin
                  newv = {q[CELL_BITS-1:FG_BITS], fg_ff};
                  chg = (q[FG_BITS-1:0] != fg_ff);
               end else begin
                  newv = (op_ff == OP_ERASE_SPAN) ? blank_ff[CELL_BITS-1:0] : cval_ff;
                  chg = (q != newv);
               end
               if (chg) begin
                  cell_we = 1'b1;
                  cell_wdata = {1'b1, newv};
                  if (!d) begin
                     if ({1'b0, row_ff} < top_ff) begin
                        top_in = {1'b0, row_ff};
                     end
                     if (row_ff > bot_ff) begin
                        bot_in = row_ff;
                     end
                     if (!ne_ff) begin
                        ne_in = 1'b1;
                        left_in = x_ff;
                        right_in = x_ff;
                     end else begin
                        if (x_ff < left_ff) left_in = x_ff;
                        if (x_ff > right_ff) right_in = x_ff;
                     end
                     erased_in = 1'b0;
                  end
               end
               if (op_ff == OP_ERASE_SPAN && (8'(x_ff) + 8'd1) < end_ff) begin
                  x_in = x_ff + 1'b1;
                  state_in = S_CRD;
               end else begin
                  state_in = S_BWR;
               end
            end
         end
         S_BWR: begin
            bnd_we = 1'b1;
            bnd_wdata = {ne_ff, left_ff, right_ff};
            state_in = S_IDLE;
         end
         S_FIN: begin
            if (out_free) begin
               rv_in = 1'b1;
               ocol_in = cr_valid_ff ? 7'(cr_col_ff) : 7'd0;
               orow_in = row_ff;
               olen_in = cr_valid_ff ? cr_len_ff : 8'd0;
               otop_in = '0;
               obot_in = '0;
               olast_in = 1'b1;
               if (inside_ff) begin
                  bnd_we = 1'b1;
                  bnd_wdata = '0;
               end
               state_in = S_IDLE;
            end
         end
         S_QRY: begin
            if (out_free) begin
               rv_in = 1'b1;
               ocol_in = '0;
               orow_in = '0;
               olen_in = '0;
               otop_in = top_ff;
               obot_in = bot_ff;
               olast_in = 1'b1;
               top_in = eh;
               bot_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         sweep_ff <= '0;
         sweep_val_ff <= '0;
         top_ff <= (int'(HEIGHT_RESET) > MAX_ROWS) ? 7'(MAX_ROWS) : HEIGHT_RESET;
         bot_ff <= '0;
         erased_ff <= 1'b1;
         cr_valid_ff <= 1'b0;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         blank_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         sweep_val_ff <= sweep_val_in;
         top_ff <= top_in;
         bot_ff <= bot_in;
         erased_ff <= erased_in;
         cr_valid_ff <= cr_valid_in;
         width_ff <= width_in;
         height_ff <= height_in;
         blank_ff <= blank_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;         row_ff <= row_in;         end_ff <= end_in;
      cval_ff <= cval_in;     fg_ff <= fg_in;           inside_ff <= inside_in;
      x_ff <= x_in;           ne_ff <= ne_in;           left_ff <= left_in;
      right_ff <= right_in;   run_len_ff <= run_len_in; run_col_ff <= run_col_in;
      cr_col_ff <= cr_col_in; cr_len_ff <= cr_len_in;
      ocol_ff <= ocol_in;     orow_ff <= orow_in;       olen_ff <= olen_in;
      otop_ff <= otop_in;     obot_ff <= obot_in;       olast_ff <= olast_in;
   end
endmodule

### rtl/core/cell_dirty_tracker_span_flush.sv
// top level of the character cell store with dirty tracking and span flush
//
// req channel: one beat per command (write cell, write foreground, erase span,
// erase all, flush row, bounds query). rsp channel: flush and bounds results,
// with last set on the final beat of a command. csr port: plain register writes,
// only while the block is idle: a user rule the block does not enforce.
// the cells and their dirty bits share one synchronous ram, the per-row bounds
// a second; a command reads a cell, then writes it back where it changes.
// an erase all writes one ram entry a cycle. a flush row walks the cells
// between the row's bounds and closes with a final beat; writes and erases
// give no beat.
// after reset a clearing pass writes every cell ram entry with req.ready low;
// csr writes are taken.
// a stalled receiver holds the output register; a flush then waits before
// handing over its next run, and no beat is dropped.
module cell_dirty_tracker_span_flush #(
   parameter int MAX_COLS  = cdt_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS  = cdt_pkg::MAX_ROWS_DEF,
   parameter int CELL_BITS = cdt_pkg::CELL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cdt_req_if.sink               req,
   cdt_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  cdt_pkg::csr_data_type csr_write_data
);
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int BND_W  = 2 * COL_W + 1;

   logic                 cell_we;
   logic [ADDR_W-1:0]    cell_waddr, cell_raddr;
   logic [CELL_BITS:0]   cell_wdata, cell_rdata;
   logic                 bnd_we;
   logic [ROW_AW-1:0]    bnd_addr;
   logic [BND_W-1:0]     bnd_wdata, bnd_rdata;

   cdt_ram #(.WIDTH(CELL_BITS + 1), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   cdt_ram #(.WIDTH(BND_W), .DEPTH(MAX_ROWS), .ADDR_W(ROW_AW)) u_bnd_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (bnd_addr),
      .wr_data (bnd_wdata),
      .rd_addr (bnd_addr),
      .rd_data (bnd_rdata)
   );

   cdt_ctrl #(
      .MAX_COLS (MAX_COLS), .MAX_ROWS (MAX_ROWS), .CELL_BITS (CELL_BITS),
      .ADDR_W (ADDR_W), .ROW_AW (ROW_AW), .COL_W (COL_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cell_we          (cell_we),
      .cell_waddr       (cell_waddr),
      .cell_wdata       (cell_wdata),
      .cell_raddr       (cell_raddr),
      .cell_rdata       (cell_rdata),
      .bnd_we           (bnd_we),
      .bnd_addr         (bnd_addr),
      .bnd_wdata        (bnd_wdata),
      .bnd_rdata        (bnd_rdata)
   );
endmodule

### rtl/core/cdt_checker.sv
// port level checks on the cell dirty tracker, bound to the top level
module cdt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_col,
   input logic [7:0] rsp_out_length,
   input logic [6:0] rsp_frame_top,
   input logic [5:0] rsp_frame_bottom
);
   // clearing pass holds off commands after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // a run beat never carries frame bounds
   a_run_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_length != 8'd0 |-> rsp_frame_top == 7'd0 && rsp_frame_bottom == 6'd0)
      else $error("run beat with frame bounds");

   a_run_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b0, rsp_out_col} + {1'b0, rsp_out_length}) <= 9'd128)
      else $error("run beyond end of row");
endmodule

bind cell_dirty_tracker_span_flush cdt_checker u_cdt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_col      (rsp.out_col),
   .rsp_out_length   (rsp.out_length),
   .rsp_frame_top    (rsp.frame_top),
   .rsp_frame_bottom (rsp.frame_bottom)
);
